// File: rtl/sbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave byte framer package
// Shared constants, register indexes, transaction payload types and the
// frame parser phase type.
// ----------------------------------------------------------------------------
package sbf_pkg;

    localparam int BYTE_W          = 8;
    localparam int PAYLOAD_BYTES   = 8;
    localparam int PAYLOAD_IDX_W   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int FRAME_PAYLOAD_W = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RX_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RX_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TX_LENGTH = 2'd2;

    // Receive modes.
    localparam logic MODE_ARRAY = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    // Pin event kinds.
    localparam logic REQ_OTHER = 1'b0;
    localparam logic REQ_SCLK  = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic  req_type;
        logic  cs_high;
        logic  edge_level;
        logic  in_bit;
        t_byte tx_byte;
    } t_sbf_in;

    typedef struct packed {
        logic [15:0]                cmd;
        logic [15:0]                src;
        logic [15:0]                dst;
        t_byte                      len;
        logic [FRAME_PAYLOAD_W-1:0] payload;
    } t_sbf_frame;

    typedef struct packed {
        logic                       out_bit;
        logic                       tx_byte_taken;
        logic                       tx_done;
        logic                       rx_byte_valid;
        t_byte                      rx_byte;
        logic                       rx_done;
        logic                       frame_valid;
        logic [15:0]                frame_cmd;
        logic [15:0]                frame_src;
        logic [15:0]                frame_dst;
        t_byte                      frame_len;
        logic [FRAME_PAYLOAD_W-1:0] frame_payload;
    } t_sbf_out;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CMD_HI,
        PH_CMD_LO,
        PH_SRC_HI,
        PH_SRC_LO,
        PH_DST_HI,
        PH_DST_LO,
        PH_LEN,
        PH_DATA
    } t_parse_phase;

endpackage

// File: rtl/sbf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave byte framer input channel
// Valid/ready channel carrying one pin event per transaction.
// ----------------------------------------------------------------------------
interface sbf_in_if import sbf_pkg::*; ();

    logic    valid;
    logic    ready;
    t_sbf_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/sbf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave byte framer output channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface sbf_out_if import sbf_pkg::*; ();

    logic     valid;
    logic     ready;
    t_sbf_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/sbf_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave byte framer frame parser
// Waits for two sync bytes, then collects command, source, destination,
// length and the payload bytes; flags the frame on its last byte.
// ----------------------------------------------------------------------------
module sbf_frame_parser import sbf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  t_byte      i_byte,
    output logic       o_frame_valid,
    output t_sbf_frame o_frame
);

    t_parse_phase             r_phase, n_phase;
    logic [PAYLOAD_IDX_W-1:0] r_data_idx, n_data_idx;
    t_byte                    r_cmd_hi, r_cmd_lo, r_src_hi, r_src_lo;
    t_byte                    r_dst_hi, r_dst_lo, r_len;
    t_byte                    r_payload [PAYLOAD_BYTES];
    logic                     last_data;

    assign last_data = (r_data_idx == PAYLOAD_IDX_W'(PAYLOAD_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC1;
            r_data_idx <= '0;
        end else begin
            r_phase    <= n_phase;
            r_data_idx <= n_data_idx;
        end
    end

    // Field bytes need no reset: every one is rewritten before a frame completes.
    always_ff @(posedge i_clk) begin
        if (i_byte_valid) begin
            unique case (r_phase)
                PH_CMD_HI: r_cmd_hi <= i_byte;
                PH_CMD_LO: r_cmd_lo <= i_byte;
                PH_SRC_HI: r_src_hi <= i_byte;
                PH_SRC_LO: r_src_lo <= i_byte;
                PH_DST_HI: r_dst_hi <= i_byte;
                PH_DST_LO: r_dst_lo <= i_byte;
                PH_LEN:    r_len    <= i_byte;
                PH_DATA:   r_payload[r_data_idx] <= i_byte;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_data_idx    = r_data_idx;
        o_frame_valid = 1'b0;
        o_frame       = '0;
        if (i_byte_valid) begin
            unique case (r_phase)
                PH_SYNC1:  if (i_byte == SYNC_BYTE) n_phase = PH_SYNC2;
                PH_SYNC2:  if (i_byte == SYNC_BYTE) n_phase = PH_CMD_HI;
                PH_CMD_HI: n_phase = PH_CMD_LO;
                PH_CMD_LO: n_phase = PH_SRC_HI;
                PH_SRC_HI: n_phase = PH_SRC_LO;
                PH_SRC_LO: n_phase = PH_DST_HI;
                PH_DST_HI: n_phase = PH_DST_LO;
                PH_DST_LO: n_phase = PH_LEN;
                PH_LEN: begin
                    n_phase    = PH_DATA;
                    n_data_idx = '0;
                end
                PH_DATA: begin
                    if (last_data) begin
                        n_phase       = PH_SYNC1;
                        n_data_idx    = '0;
                        o_frame_valid = 1'b1;
                        o_frame.cmd   = {r_cmd_hi, r_cmd_lo};
                        o_frame.src   = {r_src_hi, r_src_lo};
                        o_frame.dst   = {r_dst_hi, r_dst_lo};
                        o_frame.len   = r_len;
                        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                            o_frame.payload[FRAME_PAYLOAD_W-1-BYTE_W*i -: BYTE_W] =
                                (i == PAYLOAD_BYTES - 1) ? i_byte : r_payload[i];
                        end
                    end else begin
                        n_data_idx = r_data_idx + 1'b1;
                    end
                end
                default: n_phase = PH_SYNC1;
            endcase
        end
    end

endmodule

// File: rtl/spi_slave_byte_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave byte framer
// Mode 1 style SPI slave fed with one sampled pin event per transaction,
// with array-mode byte counting and a sync-headed frame parser.
// ----------------------------------------------------------------------------
// The block takes one pin event per input transaction and returns exactly one
// result transaction for it. It sustains one event per clock cycle while the
// output is not stalled; an accepted event waits in the input register and its
// result is then loaded into the result register, from which it is offered.
// Either side may stall freely. While chip select is high the bit counters and
// the receive shift register are cleared and the data output is driven low.
// With select low, a fresh transmit byte is taken from the input at the start
// of every byte while transmit count remains (reported through tx_byte_taken),
// rising serial clock edges drive its bits MSB first and falling edges sample
// the data input MSB first. Completed bytes are either counted towards
// rx_length (array mode) or fed to the frame parser (frame mode), which reports
// a whole frame on its last payload byte. Configuration writes take effect at
// once and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module spi_slave_byte_framer_unit import sbf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sbf_in_if.sink                i_in,
    sbf_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Pipeline control: an input register feeding a result register.
    logic     r_s1_valid, r_out_valid;
    t_sbf_in  r_s1;
    t_sbf_out r_out, n_out;
    logic     out_free, s1_adv, in_acc;

    // Configuration registers.
    logic  r_rx_mode, n_rx_mode;
    t_byte r_rx_length, n_rx_length;
    t_byte r_tx_length, n_tx_length;

    // Serial and counting state.
    logic [2:0] r_drive_idx, n_drive_idx;
    logic [2:0] r_sample_idx, n_sample_idx;
    t_byte      r_rx_shift, n_rx_shift;
    t_byte      r_tx_hold, n_tx_hold;
    logic       r_tx_need_load, n_tx_need_load;
    t_byte      r_tx_sent, n_tx_sent;
    logic       r_tx_active, n_tx_active;
    t_byte      r_rx_received, n_rx_received;
    logic       r_rx_active, n_rx_active;
    logic       r_out_level, n_out_level;

    // Event decode for the item in the input register.
    logic       sel_low, rise, fall, byte_done, frame_byte;
    t_byte      hold_eff, shift_eff, sent_inc, recv_inc;
    logic       frame_valid;
    t_sbf_frame frame;

    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_in.ready  = !r_s1_valid || out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    assign sel_low    = !r_s1.cs_high;
    assign rise       = sel_low && r_s1.req_type == REQ_SCLK && r_s1.edge_level;
    assign fall       = sel_low && r_s1.req_type == REQ_SCLK && !r_s1.edge_level;
    assign byte_done  = fall && (r_sample_idx == 3'd7);
    assign frame_byte = s1_adv && byte_done && r_rx_mode == MODE_FRAME;
    assign sent_inc   = r_tx_sent + 1'b1;
    assign recv_inc   = r_rx_received + 1'b1;

    // A byte is loaded on the first select-low event of every byte; with no
    // transmit count left, zeros are shifted out instead.
    always_comb begin
        hold_eff = r_tx_hold;
        if (r_tx_need_load) begin
            hold_eff = r_tx_active ? r_s1.tx_byte : '0;
        end
        shift_eff = r_rx_shift;
        if (r_s1.in_bit) begin
            shift_eff[3'd7 - r_sample_idx] = 1'b1;
        end
    end

    sbf_frame_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (frame_byte),
        .i_byte        (shift_eff),
        .o_frame_valid (frame_valid),
        .o_frame       (frame)
    );

    always_comb begin
        n_rx_mode      = r_rx_mode;
        n_rx_length    = r_rx_length;
        n_tx_length    = r_tx_length;
        n_drive_idx    = r_drive_idx;
        n_sample_idx   = r_sample_idx;
        n_rx_shift     = r_rx_shift;
        n_tx_hold      = r_tx_hold;
        n_tx_need_load = r_tx_need_load;
        n_tx_sent      = r_tx_sent;
        n_tx_active    = r_tx_active;
        n_rx_received  = r_rx_received;
        n_rx_active    = r_rx_active;
        n_out_level    = r_out_level;
        n_out          = '0;

        if (s1_adv) begin
            if (!sel_low) begin
                n_drive_idx    = '0;
                n_sample_idx   = '0;
                n_rx_shift     = '0;
                n_out_level    = 1'b0;
                n_tx_need_load = 1'b1;
            end else begin
                if (r_tx_need_load) begin
                    n_tx_need_load = 1'b0;
                    n_tx_hold      = hold_eff;
                    if (r_tx_active) begin
                        n_out.tx_byte_taken = 1'b1;
                        n_tx_sent           = sent_inc;
                        if (sent_inc == r_tx_length) begin
                            n_tx_sent     = '0;
                            n_tx_active   = 1'b0;
                            n_out.tx_done = 1'b1;
                        end
                    end
                end
                if (rise) begin
                    n_out_level = hold_eff[3'd7 - r_drive_idx];
                    n_drive_idx = r_drive_idx + 1'b1;
                    if (r_drive_idx == 3'd7) begin
                        n_tx_need_load = 1'b1;
                    end
                end
                if (fall) begin
                    n_sample_idx = r_sample_idx + 1'b1;
                    n_rx_shift   = shift_eff;
                    if (byte_done) begin
                        n_rx_shift    = '0;
                        n_out.rx_byte = shift_eff;
                        if (r_rx_mode == MODE_ARRAY && r_rx_active) begin
                            n_out.rx_byte_valid = 1'b1;
                            n_rx_received       = recv_inc;
                            if (recv_inc == r_rx_length) begin
                                n_rx_received = '0;
                                n_rx_active   = 1'b0;
                                n_out.rx_done = 1'b1;
                            end
                        end
                    end
                end
            end
            n_out.out_bit       = n_out_level;
            n_out.frame_valid   = frame_valid;
            n_out.frame_cmd     = frame.cmd;
            n_out.frame_src     = frame.src;
            n_out.frame_dst     = frame.dst;
            n_out.frame_len     = frame.len;
            n_out.frame_payload = frame.payload;
        end

        // Writes must arrive only while idle; the block itself does not enforce this.
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RX_MODE: n_rx_mode = i_cfg_wdata[0];
                REG_RX_LENGTH: begin
                    n_rx_length   = i_cfg_wdata;
                    n_rx_active   = (i_cfg_wdata != '0);
                    n_rx_received = '0;
                end
                REG_TX_LENGTH: begin
                    n_tx_length = i_cfg_wdata;
                    n_tx_active = (i_cfg_wdata != '0);
                    n_tx_sent   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_rx_mode      <= MODE_ARRAY;
            r_rx_length    <= '0;
            r_tx_length    <= '0;
            r_drive_idx    <= '0;
            r_sample_idx   <= '0;
            r_rx_shift     <= '0;
            r_tx_hold      <= '0;
            r_tx_need_load <= 1'b1;
            r_tx_sent      <= '0;
            r_tx_active    <= 1'b0;
            r_rx_received  <= '0;
            r_rx_active    <= 1'b0;
            r_out_level    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_rx_mode      <= n_rx_mode;
            r_rx_length    <= n_rx_length;
            r_tx_length    <= n_tx_length;
            r_drive_idx    <= n_drive_idx;
            r_sample_idx   <= n_sample_idx;
            r_rx_shift     <= n_rx_shift;
            r_tx_hold      <= n_tx_hold;
            r_tx_need_load <= n_tx_need_load;
            r_tx_sent      <= n_tx_sent;
            r_tx_active    <= n_tx_active;
            r_rx_received  <= n_rx_received;
            r_rx_active    <= n_rx_active;
            r_out_level    <= n_out_level;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in.payload;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    // A finished transmit count implies the byte that finished it was taken.
    a_tx_done_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.tx_done |-> r_out.tx_byte_taken)
        else $error("tx_done without a taken transmit byte");

    // Array completion only comes with a stored byte.
    a_rx_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rx_done |-> r_out.rx_byte_valid)
        else $error("rx_done without a stored byte");

    // Array storage and frame completion belong to different modes.
    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.frame_valid && r_out.rx_byte_valid))
        else $error("frame and array results in one transaction");

    // The sent count rests at zero whenever transmission is inactive.
    a_tx_sent_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tx_active |-> r_tx_sent == '0)
        else $error("transmit count left over while inactive");

    // Frame fields stay clear unless a frame completed.
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.frame_valid |-> r_out.frame_cmd == '0 && r_out.frame_len == '0)
        else $error("frame fields set without a frame");

endmodule
